### rtl/core/ale_pkg.sv
// Package for the array list engine: opcodes, status codes and the
// command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

    // Command opcodes
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_LOCATE = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_POS   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Walk index control
    typedef enum logic [2:0] {
        IDX_HOLD      = 3'd0,
        IDX_LOAD_ZERO = 3'd1,
        IDX_LOAD_POS  = 3'd2,
        IDX_LOAD_LAST = 3'd3,
        IDX_INC       = 3'd4,
        IDX_DEC       = 3'd5
    } idx_op_t;

    // Store write control
    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_UP    = 2'd1,
        WR_DOWN  = 2'd2,
        WR_PUT   = 2'd3
    } wr_op_t;

    // Length register control
    typedef enum logic [1:0] {
        LEN_HOLD = 2'd0,
        LEN_INC  = 2'd1,
        LEN_DEC  = 2'd2,
        LEN_ZERO = 2'd3
    } len_op_t;

    // Result element register control
    typedef enum logic [1:0] {
        ELEM_HOLD  = 2'd0,
        ELEM_ZERO  = 2'd1,
        ELEM_RDATA = 2'd2
    } elem_op_t;

    // Controller to datapath
    typedef struct packed {
        logic       latch;
        idx_op_t    idx_op;
        wr_op_t     wr_op;
        len_op_t    len_op;
        elem_op_t   elem_op;
        logic       res_load;
        logic [2:0] res_status;
        logic       found_prev;
    } ale_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       pos_in_range;
        logic       ins_ok;
        logic       ins_at_end;
        logic       idx_at_pos;
        logic       prev_at_last;
        logic       match;
    } ale_stat_t;

endpackage

`default_nettype wire

### rtl/core/ale_datapath.sv
// Datapath of the array list engine: element store, walk index, length
// and result registers. Driven by ale_ctrl; depends on ale_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ale_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [2:0]       opcode,
    input  wire logic [6:0]       position,
    input  wire logic [7:0]       value,
    input  wire ale_pkg::ale_cmd_t cmd,
    output ale_pkg::ale_stat_t    stat,
    output logic [2:0]            status,
    output logic [7:0]            element,
    output logic [6:0]            found_position,
    output logic [6:0]            length,
    output logic                  is_empty
);
    import ale_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    // Element store
    logic [7:0]    mem [CAPACITY];
    logic [7:0]    rd_data_reg;

    // Latched command
    logic [2:0]    op_reg;
    logic [6:0]    pos_reg;
    logic [7:0]    val_reg;

    // Walk index and the index read in the previous cycle
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [AW-1:0] prev_idx_reg;

    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;

    // Result registers
    logic [2:0]    status_reg;
    logic [7:0]    element_reg;
    logic [6:0]    found_reg;

    logic [CW-1:0] pos_x;
    logic [CW-1:0] len_x;
    logic [CW-1:0] found_x;
    logic [AW-1:0] pos_m1;
    logic [AW-1:0] len_m1;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Position and length compares
    always_comb
    begin
        pos_x   = CW'(pos_reg);
        len_x   = CW'(len_reg);
        pos_m1  = AW'(pos_x - CW'(1));
        len_m1  = AW'(len_reg - LW'(1));
        found_x = CW'(prev_idx_reg) + CW'(1);

        stat.op           = op_reg;
        stat.full         = (len_reg >= LW'(CAPACITY));
        stat.empty        = (len_reg == '0);
        stat.pos_in_range = (pos_reg != '0) && (pos_x <= len_x);
        stat.ins_ok       = (pos_reg != '0) && (pos_x <= len_x + CW'(1));
        stat.ins_at_end   = (pos_x == len_x + CW'(1));
        stat.idx_at_pos   = (idx_reg == pos_m1);
        stat.prev_at_last = (prev_idx_reg == len_m1);
        stat.match        = (rd_data_reg == val_reg);
    end

    // Next walk index
    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:      idx_next = idx_reg;
            IDX_LOAD_ZERO: idx_next = '0;
            IDX_LOAD_POS:  idx_next = pos_m1;
            IDX_LOAD_LAST: idx_next = len_m1;
            IDX_INC:       idx_next = idx_reg + AW'(1);
            IDX_DEC:       idx_next = idx_reg - AW'(1);
            default:       idx_next = idx_reg;
        endcase
    end

    // Store write port: shift moves take the element read last cycle
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = pos_m1;
        wr_data = rd_data_reg;
        case (cmd.wr_op)
            WR_NONE: wr_en   = 1'b0;
            WR_UP:   wr_addr = prev_idx_reg + AW'(1);
            WR_DOWN: wr_addr = prev_idx_reg - AW'(1);
            WR_PUT:  wr_data = val_reg;
            default: wr_en   = 1'b0;
        endcase
    end

    // Next length
    always_comb
    begin
        case (cmd.len_op)
            LEN_HOLD: len_next = len_reg;
            LEN_INC:  len_next = len_reg + LW'(1);
            LEN_DEC:  len_next = len_reg - LW'(1);
            LEN_ZERO: len_next = '0;
            default:  len_next = len_reg;
        endcase
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // Length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Command latch, walk index and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= value;
        end
        idx_reg      <= idx_next;
        prev_idx_reg <= idx_reg;
        case (cmd.elem_op)
            ELEM_HOLD:  element_reg <= element_reg;
            ELEM_ZERO:  element_reg <= '0;
            ELEM_RDATA: element_reg <= rd_data_reg;
            default:    element_reg <= element_reg;
        endcase
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            found_reg  <= cmd.found_prev ? 7'(found_x) : 7'd0;
        end
    end

    assign status         = status_reg;
    assign element        = element_reg;
    assign found_position = found_reg;
    assign length         = 7'(len_reg);
    assign is_empty       = (len_reg == '0);

    // Checks
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.res_status != ST_OK) |=> $stable(len_reg))
        else $error("failed command changed the length");

endmodule

`default_nettype wire

### rtl/core/ale_ctrl.sv
// Controller of the array list engine: decodes each command and sequences
// the store walks of ale_datapath. Depends on ale_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ale_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ale_pkg::ale_stat_t stat,
    output ale_pkg::ale_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);
    import ale_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'h0001,
        S_DECODE    = 13'h0002,
        S_GET_WAIT  = 13'h0004,
        S_GET_DATA  = 13'h0008,
        S_LOC_FIRST = 13'h0010,
        S_LOC_RUN   = 13'h0020,
        S_INS_FIRST = 13'h0040,
        S_INS_SHIFT = 13'h0080,
        S_INS_DRAIN = 13'h0100,
        S_INS_PUT   = 13'h0200,
        S_DEL_RD    = 13'h0400,
        S_DEL_TAKE  = 13'h0800,
        S_DEL_SHIFT = 13'h1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // Next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // Default: finish at once with status ok
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.elem_op    = ELEM_ZERO;
                state_next     = S_IDLE;
                case (stat.op)
                    OP_GET:
                    begin
                        if (!stat.pos_in_range)
                        begin
                            cmd.res_status = ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.idx_op   = IDX_LOAD_POS;
                            state_next   = S_GET_WAIT;
                        end
                    end
                    OP_LOCATE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.idx_op   = IDX_LOAD_ZERO;
                            state_next   = S_LOC_FIRST;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else if (!stat.ins_ok)
                        begin
                            cmd.res_status = ST_BAD_POS;
                        end
                        else if (stat.ins_at_end)
                        begin
                            // Append: no tail to move
                            cmd.res_load = 1'b0;
                            state_next   = S_INS_PUT;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.idx_op   = IDX_LOAD_LAST;
                            state_next   = S_INS_FIRST;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = ST_EMPTY;
                        end
                        else if (!stat.pos_in_range)
                        begin
                            cmd.res_status = ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.idx_op   = IDX_LOAD_POS;
                            state_next   = S_DEL_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.len_op = LEN_ZERO;
                    end
                    default:
                    begin
                        cmd.res_status = ST_OK;
                    end
                endcase
            end

            // Get: one read, the registered data is taken in S_GET_DATA
            S_GET_WAIT:
            begin
                state_next = S_GET_DATA;
            end

            S_GET_DATA:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.elem_op    = ELEM_RDATA;
                state_next     = S_IDLE;
            end

            // Locate: read ahead one entry, compare the previous read
            S_LOC_FIRST:
            begin
                cmd.idx_op = IDX_INC;
                state_next = S_LOC_RUN;
            end

            S_LOC_RUN:
            begin
                if (stat.match)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.elem_op    = ELEM_ZERO;
                    cmd.found_prev = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.prev_at_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    cmd.elem_op    = ELEM_ZERO;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end

            // Insert: walk down from the last element moving each up by one
            S_INS_FIRST:
            begin
                if (stat.idx_at_pos)
                begin
                    state_next = S_INS_DRAIN;
                end
                else
                begin
                    cmd.idx_op = IDX_DEC;
                    state_next = S_INS_SHIFT;
                end
            end

            S_INS_SHIFT:
            begin
                cmd.wr_op = WR_UP;
                if (stat.idx_at_pos)
                begin
                    state_next = S_INS_DRAIN;
                end
                else
                begin
                    cmd.idx_op = IDX_DEC;
                end
            end

            S_INS_DRAIN:
            begin
                cmd.wr_op  = WR_UP;
                state_next = S_INS_PUT;
            end

            S_INS_PUT:
            begin
                cmd.wr_op      = WR_PUT;
                cmd.len_op     = LEN_INC;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.elem_op    = ELEM_ZERO;
                state_next     = S_IDLE;
            end

            // Delete: take the element, then move the tail down by one
            S_DEL_RD:
            begin
                cmd.idx_op = IDX_INC;
                state_next = S_DEL_TAKE;
            end

            S_DEL_TAKE:
            begin
                cmd.elem_op = ELEM_RDATA;
                if (stat.prev_at_last)
                begin
                    cmd.len_op     = LEN_DEC;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_DEL_SHIFT;
                end
            end

            S_DEL_SHIFT:
            begin
                cmd.wr_op = WR_DOWN;
                if (stat.prev_at_last)
                begin
                    cmd.len_op     = LEN_DEC;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.res_load;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> (state_reg == S_IDLE && done_reg))
        else $error("result loaded without strobe and return to idle");

endmodule

`default_nettype wire

### rtl/core/array_list_engine_top.sv
// Top level of the array list engine: ordered byte list with get, locate,
// insert, delete and clear. Instantiates ale_ctrl and ale_datapath.
//
// channel   direction  handshake             payload
// command   in         start, busy           opcode, position, value
// result    out        done (one-cycle)      status, element, found_position,
//                                            length, is_empty
//
// A command is taken when start is high and busy is low; done marks its single
// result for one cycle, and busy is low again in that cycle.
// Clear, bad commands and failures finish from the decode state; get reads one
// entry. Locate, insert and delete walk the single-port element store one entry
// per cycle: locate up to the matching position, insert from the last element
// down to position p (append moves nothing), delete from p to the end.
// Reset clears the length and the controller; the store needs no clearing.
// The result side cannot stall; results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] opcode,
    input  wire logic [6:0] position,
    input  wire logic [7:0] value,
    output logic            done,
    output logic [2:0]      status,
    output logic [7:0]      element,
    output logic [6:0]      found_position,
    output logic [6:0]      length,
    output logic            is_empty
);
    import ale_pkg::*;

    ale_cmd_t  cmd;
    ale_stat_t stat;

    // Sequencer
    ale_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Store and result registers
    ale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .opcode         (opcode),
        .position       (position),
        .value          (value),
        .cmd            (cmd),
        .stat           (stat),
        .status         (status),
        .element        (element),
        .found_position (found_position),
        .length         (length),
        .is_empty       (is_empty)
    );

endmodule

`default_nettype wire

### sim/array_list_engine_top_test.sv
`timescale 1ns / 1ps
// Testbench for array_list_engine_top: directed and random list commands, each
// result checked field by field against a list image kept in the bench.
// Depends on ale_pkg and the array list engine RTL.

module array_list_engine_top_test;
    import ale_pkg::*;

    localparam int CAPACITY     = 64;
    // longest walk plus margin, used once the last result is in
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

    // opcodes the block ignores
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] element;
        logic [6:0] found_position;
        logic [6:0] length;
        logic       is_empty;
    } list_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] opcode;
    logic [6:0] position;
    logic [7:0] value;
    logic       done;
    logic [2:0] status;
    logic [7:0] element;
    logic [6:0] found_position;
    logic [6:0] length;
    logic       is_empty;

    // bench copy of the list
    logic [7:0]   list_image [CAPACITY];
    int           list_count;
    list_result_t awaited_results [$];
    int           err_count = 0;
    bit           no_idle   = 1'b0;

    array_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .position       (position),
        .value          (value),
        .done           (done),
        .status         (status),
        .element        (element),
        .found_position (found_position),
        .length         (length),
        .is_empty       (is_empty)
    );

    always #4 clk = ~clk;

    // Apply one command to the list image and return the result it must give
    function automatic list_result_t list_cmd_outcome(input logic [2:0] op,
                                                      input logic [6:0] pos,
                                                      input logic [7:0] val);
        list_result_t r;
        int           p;
        int           k;
        bit           hit;
        r   = '0;
        p   = int'(pos);
        hit = 1'b0;
        r.status = ST_OK;
        case (op)
            OP_GET:
            begin
                if (p < 1 || p > list_count)
                    r.status = ST_BAD_POS;
                else
                    r.element = list_image[p-1];
            end
            OP_LOCATE:
            begin
                for (k = 0; k < list_count; k++)
                begin
                    if (!hit && list_image[k] == val)
                    begin
                        hit = 1'b1;
                        r.found_position = 7'(k + 1);
                    end
                end
                if (!hit)
                    r.status = ST_NOT_FOUND;
            end
            OP_INSERT:
            begin
                if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else if (p < 1 || p > list_count + 1)
                    r.status = ST_BAD_POS;
                else
                begin
                    for (k = list_count; k >= p; k--)
                        list_image[k] = list_image[k-1];
                    list_image[p-1] = val;
                    list_count++;
                end
            end
            OP_DELETE:
            begin
                if (list_count == 0)
                    r.status = ST_EMPTY;
                else if (p < 1 || p > list_count)
                    r.status = ST_BAD_POS;
                else
                begin
                    r.element = list_image[p-1];
                    for (k = p; k < list_count; k++)
                        list_image[k-1] = list_image[k];
                    list_count--;
                end
            end
            OP_CLEAR:
                list_count = 0;
            default:
                ;
        endcase
        r.length   = 7'(list_count);
        r.is_empty = (list_count == 0);
        return r;
    endfunction

    // Drive one item after a random gap; record its result once accepted
    task automatic send_cmd(input logic [2:0] op, input logic [6:0] pos,
                            input logic [7:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (busy);
        awaited_results.push_back(list_cmd_outcome(op, pos, val));
    endtask

    // Mostly a valid position in 1..hi, sometimes any 7-bit value
    function automatic logic [6:0] pick_pos(input int hi);
        if (hi >= 1 && $urandom_range(0, 9) < 8)
            return 7'($urandom_range(1, hi));
        return 7'($urandom_range(0, 127));
    endfunction

    // Half the values from a small pool so duplicates and hits are common
    function automatic logic [7:0] pick_val();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // Locate value: usually one held in the list
    function automatic logic [7:0] pick_search_val();
        if (list_count > 0 && $urandom_range(0, 9) < 7)
            return list_image[$urandom_range(0, list_count - 1)];
        return pick_val();
    endfunction

    task automatic test_empty_list();
        send_cmd(OP_GET,    7'd1,   8'h00);
        send_cmd(OP_DELETE, 7'd1,   8'h00);
        send_cmd(OP_LOCATE, 7'd0,   8'h00);
        send_cmd(OP_CLEAR,  7'd0,   8'h00);
    endtask

    // list ends up as 5A A5 FF 00 FF
    task automatic test_insert_positions();
        send_cmd(OP_INSERT, 7'd0,   8'h11);
        send_cmd(OP_INSERT, 7'd2,   8'h22);
        send_cmd(OP_INSERT, 7'd1,   8'hFF);
        send_cmd(OP_INSERT, 7'd2,   8'h00);
        send_cmd(OP_INSERT, 7'd1,   8'h5A);
        send_cmd(OP_INSERT, 7'd2,   8'hA5);
        send_cmd(OP_INSERT, 7'd5,   8'hFF);
    endtask

    task automatic test_read_back();
        send_cmd(OP_GET,    7'd1,   8'h00);
        send_cmd(OP_GET,    7'd5,   8'hFF);
        send_cmd(OP_GET,    7'd6,   8'h00);
        send_cmd(OP_GET,    7'd127, 8'h00);
        send_cmd(OP_LOCATE, 7'd127, 8'hFF);
        send_cmd(OP_LOCATE, 7'd0,   8'h33);
    endtask

    task automatic test_delete_positions();
        send_cmd(OP_DELETE, 7'd0,   8'h00);
        send_cmd(OP_DELETE, 7'd6,   8'h00);
        send_cmd(OP_DELETE, 7'd5,   8'h00);
        send_cmd(OP_DELETE, 7'd1,   8'h00);
    endtask

    task automatic test_clear_and_reserved();
        send_cmd(OP_RSVD5,  7'd127, 8'hFF);
        send_cmd(OP_RSVD6,  7'd127, 8'hFF);
        send_cmd(OP_RSVD7,  7'd127, 8'hFF);
        send_cmd(OP_CLEAR,  7'd127, 8'hFF);
    endtask

    // Fill to capacity, hit the full case, search deep, then drain
    task automatic test_fill_and_drain();
        int i;
        while (list_count < CAPACITY)
            send_cmd(OP_INSERT, pick_pos(list_count + 1), pick_val());
        send_cmd(OP_INSERT, 7'(CAPACITY), pick_val());
        send_cmd(OP_INSERT, 7'd0, pick_val());
        send_cmd(OP_GET, 7'(CAPACITY), 8'h00);
        send_cmd(OP_LOCATE, 7'd0, list_image[CAPACITY-1]);
        for (i = 0; i < 8; i++)
            send_cmd(OP_LOCATE, 7'($urandom_range(0, 127)), pick_search_val());
        while (list_count > 0)
            send_cmd(OP_DELETE, pick_pos(list_count), pick_val());
    endtask

    // Weighted mix of commands with random content and idle stretches
    task automatic test_random_mix(input int n_items);
        int i;
        int w;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            w = $urandom_range(0, 99);
            if (w < 38)
                send_cmd(OP_INSERT, pick_pos(list_count + 1), pick_val());
            else if (w < 60)
                send_cmd(OP_DELETE, pick_pos(list_count), pick_val());
            else if (w < 76)
                send_cmd(OP_GET, pick_pos(list_count), pick_val());
            else if (w < 94)
                send_cmd(OP_LOCATE, 7'($urandom_range(0, 127)), pick_search_val());
            else if (w < 97)
                send_cmd(OP_CLEAR, 7'($urandom_range(0, 127)), pick_val());
            else
                send_cmd(3'($urandom_range(int'(OP_RSVD5), int'(OP_RSVD7))),
                         7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
        end
        no_idle = 1'b0;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no command outstanding: status %0d", status);
                err_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    err_count++;
                end
                if (element !== want.element)
                begin
                    $error("element: expected %0d, got %0d", want.element, element);
                    err_count++;
                end
                if (found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, found_position);
                    err_count++;
                end
                if (length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, length);
                    err_count++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_GET;
        position   = 7'd0;
        value      = 8'd0;
        list_count = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_insert_positions();
        test_read_back();
        test_delete_positions();
        test_clear_and_reserved();
        test_fill_and_drain();
        test_random_mix(310);

        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
